@@ rtl/fpp_pkg.sv @@
// Shared types, widths, constants and helpers for the fisheye point projection.
`timescale 1ns / 1ps
package fpp_pkg;

  localparam int unsigned XW  = 32;  // coordinates widened to Q.28
  localparam int unsigned VW  = 36;  // vectoring datapath
  localparam int unsigned TW  = 40;  // theta vectoring datapath
  localparam int unsigned ZW  = 34;  // angle accumulator, Q.30
  localparam int unsigned CSW = 34;  // cos and sin, Q.30
  localparam int unsigned T2W = 28;  // theta squared, Q.24
  localparam int unsigned ACW = 34;  // polynomial accumulator, Q.24
  localparam int unsigned DTW = 40;  // distorted angle, Q.24
  localparam int unsigned PW  = 44;  // distorted point, Q.28
  localparam int unsigned PRW = 76;  // product width
  localparam int unsigned KW  = 24;  // register width
  localparam int unsigned OUTW = 28; // pixel width

  localparam logic signed [CSW-1:0] KINV     = CSW'(64'sd652032874);
  localparam logic signed [TW-1:0]  ONE_Q28  = TW'(64'sd268435456);
  localparam logic signed [ACW-1:0] ONE_Q24  = ACW'(64'sd16777216);
  localparam logic signed [OUTW-1:0] PIX_MAX = {1'b0, {(OUTW-1){1'b1}}};
  localparam logic signed [OUTW-1:0] PIX_MIN = {1'b1, {(OUTW-1){1'b0}}};

  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_K2 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_K3 = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_K4 = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_K5 = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FU = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FV = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CU = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CV = 8'd7;

  // Polynomial pipeline operations, one per stage in this order.
  localparam int unsigned OP_SQUARE  = 0;
  localparam int unsigned OP_MUL1    = 1;
  localparam int unsigned OP_ADD_K4  = 2;
  localparam int unsigned OP_MUL2    = 3;
  localparam int unsigned OP_ADD_K3  = 4;
  localparam int unsigned OP_MUL3    = 5;
  localparam int unsigned OP_ADD_K2  = 6;
  localparam int unsigned OP_MUL4    = 7;
  localparam int unsigned OP_ADD_ONE = 8;
  localparam int unsigned OP_MUL_Z   = 9;
  localparam int unsigned OP_DTH     = 10;
  localparam int unsigned OP_MUL_CS  = 11;
  localparam int unsigned OP_ROUND_P = 12;
  localparam int unsigned POLY_STAGES = 13;

  typedef struct packed {
    logic signed [KW-1:0] k2;
    logic signed [KW-1:0] k3;
    logic signed [KW-1:0] k4;
    logic signed [KW-1:0] k5;
    logic [KW-1:0]        fu;
    logic [KW-1:0]        fv;
    logic [KW-1:0]        cu;
    logic [KW-1:0]        cv;
  } cfg_t;

  typedef struct packed {
    logic                  use_dist;
    logic                  fold;
    logic signed [XW-1:0]  x;
    logic signed [XW-1:0]  y;
    logic signed [VW-1:0]  vx;
    logic signed [VW-1:0]  vy;
    logic signed [CSW-1:0] cx;
    logic signed [CSW-1:0] cy;
  } vec_t;

  typedef struct packed {
    logic                  use_dist;
    logic signed [XW-1:0]  x;
    logic signed [XW-1:0]  y;
    logic signed [CSW-1:0] cx;
    logic signed [CSW-1:0] cy;
    logic signed [TW-1:0]  tx;
    logic signed [TW-1:0]  ty;
    logic signed [ZW-1:0]  z;
  } theta_t;

  typedef struct packed {
    logic                  use_dist;
    logic signed [XW-1:0]  x;
    logic signed [XW-1:0]  y;
    logic signed [CSW-1:0] cx;
    logic signed [CSW-1:0] cy;
    logic signed [ZW-1:0]  z;
    logic signed [T2W-1:0] t2;
    logic signed [ACW-1:0] acc;
    logic signed [DTW-1:0] dth;
    logic signed [PRW-1:0] pa;
    logic signed [PRW-1:0] pb;
    logic signed [PW-1:0]  px;
    logic signed [PW-1:0]  py;
  } poly_t;

  // Round half up: add half an LSB of the result, then shift with floor.
  function automatic logic signed [PRW-1:0] rnd(input logic signed [PRW-1:0] p,
                                                input int unsigned s);
    logic signed [PRW-1:0] half;
    logic signed [PRW-1:0] sum;
    half = '0;
    half[s-1] = 1'b1;
    sum = p + half;
    return sum >>> s;
  endfunction

  // Arctangent of 2^-i in Q.30.
  function automatic logic signed [ZW-1:0] atan_q30(input int unsigned i);
    logic [31:0] v;
    case (i)
      0: v = 32'h3243F6A8;  1: v = 32'h1DAC6705;  2: v = 32'h0FADBAFC;
      3: v = 32'h07F56EA6;  4: v = 32'h03FEAB76;  5: v = 32'h01FFD55B;
      6: v = 32'h00FFFAAA;  7: v = 32'h007FFF55;  8: v = 32'h003FFFEA;
      9: v = 32'h001FFFFD;  10: v = 32'h000FFFFF; 11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF; 14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF; 16: v = 32'h00003FFF; 17: v = 32'h00001FFF;
      18: v = 32'h00000FFF; 19: v = 32'h000007FF; 20: v = 32'h000003FF;
      21: v = 32'h000001FF; 22: v = 32'h000000FF; 23: v = 32'h0000007F;
      24: v = 32'h0000003F; 25: v = 32'h0000001F; 26: v = 32'h0000000F;
      27: v = 32'h00000008; 28: v = 32'h00000004; 29: v = 32'h00000002;
      30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return ZW'(signed'({1'b0, v}));
  endfunction

endpackage

@@ rtl/fpp_vec_step.sv @@
// One CORDIC vectoring step on the point, with the matching rotation of the unit vector.
`timescale 1ns / 1ps
module fpp_vec_step
  import fpp_pkg::*;
#(
  parameter int unsigned STEP = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_valid,
  input  vec_t in_data,
  output logic out_valid,
  output vec_t out_data
);

  logic valid_r;
  vec_t data_r;
  vec_t data_nxt;
  logic dir;

  always_comb begin
    data_nxt = in_data;
    dir = ~in_data.vy[VW-1];
    if (dir) begin
      data_nxt.vx = in_data.vx + (in_data.vy >>> STEP);
      data_nxt.vy = in_data.vy - (in_data.vx >>> STEP);
      data_nxt.cx = in_data.cx - (in_data.cy >>> STEP);
      data_nxt.cy = in_data.cy + (in_data.cx >>> STEP);
    end else begin
      data_nxt.vx = in_data.vx - (in_data.vy >>> STEP);
      data_nxt.vy = in_data.vy + (in_data.vx >>> STEP);
      data_nxt.cx = in_data.cx + (in_data.cy >>> STEP);
      data_nxt.cy = in_data.cy - (in_data.cx >>> STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

@@ rtl/fpp_theta_step.sv @@
// One CORDIC vectoring step on (1, r) that accumulates the incidence angle.
`timescale 1ns / 1ps
module fpp_theta_step
  import fpp_pkg::*;
#(
  parameter int unsigned STEP = 0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   in_valid,
  input  theta_t in_data,
  output logic   out_valid,
  output theta_t out_data
);

  localparam logic signed [ZW-1:0] ANGLE = atan_q30(STEP);

  logic   valid_r;
  theta_t data_r;
  theta_t data_nxt;

  always_comb begin
    data_nxt = in_data;
    if (!in_data.ty[TW-1]) begin
      data_nxt.tx = in_data.tx + (in_data.ty >>> STEP);
      data_nxt.ty = in_data.ty - (in_data.tx >>> STEP);
      data_nxt.z  = in_data.z + ANGLE;
    end else begin
      data_nxt.tx = in_data.tx - (in_data.ty >>> STEP);
      data_nxt.ty = in_data.ty + (in_data.tx >>> STEP);
      data_nxt.z  = in_data.z - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

@@ rtl/fpp_poly_stage.sv @@
// One stage of the distortion polynomial and distorted-point pipeline.
`timescale 1ns / 1ps
module fpp_poly_stage
  import fpp_pkg::*;
#(
  parameter int unsigned OP = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  cfg_t  cfg,
  input  logic  in_valid,
  input  poly_t in_data,
  output logic  out_valid,
  output poly_t out_data
);

  logic  valid_r;
  poly_t data_r;
  poly_t data_nxt;

  always_comb begin
    data_nxt = in_data;
    case (OP)
      OP_SQUARE: begin
        data_nxt.pa  = PRW'(in_data.z) * PRW'(in_data.z);
        data_nxt.t2  = T2W'(rnd(data_nxt.pa, 36));
        data_nxt.acc = ACW'(cfg.k5) <<< 2;
      end
      OP_MUL1, OP_MUL2, OP_MUL3, OP_MUL4: begin
        data_nxt.pa = PRW'(in_data.t2) * PRW'(in_data.acc);
      end
      OP_ADD_K4: data_nxt.acc = (ACW'(cfg.k4) <<< 2) + ACW'(rnd(in_data.pa, 24));
      OP_ADD_K3: data_nxt.acc = (ACW'(cfg.k3) <<< 2) + ACW'(rnd(in_data.pa, 24));
      OP_ADD_K2: data_nxt.acc = (ACW'(cfg.k2) <<< 2) + ACW'(rnd(in_data.pa, 24));
      OP_ADD_ONE: data_nxt.acc = ONE_Q24 + ACW'(rnd(in_data.pa, 24));
      OP_MUL_Z: data_nxt.pa = PRW'(in_data.z) * PRW'(in_data.acc);
      OP_DTH: data_nxt.dth = DTW'(rnd(in_data.pa, 30));
      OP_MUL_CS: begin
        data_nxt.pa = PRW'(in_data.dth) * PRW'(in_data.cx);
        data_nxt.pb = PRW'(in_data.dth) * PRW'(in_data.cy);
      end
      OP_ROUND_P: begin
        data_nxt.px = PW'(rnd(in_data.pa, 26));
        data_nxt.py = PW'(rnd(in_data.pb, 26));
      end
      default: data_nxt = in_data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

@@ rtl/fpp_pixel.sv @@
// Focal scaling, principal point offset and saturation, in two register stages.
`timescale 1ns / 1ps
module fpp_pixel
  import fpp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  cfg_t                   cfg,
  input  logic                   in_valid,
  input  poly_t                  in_data,
  output logic                   out_valid,
  output logic signed [OUTW-1:0] pixel_u,
  output logic signed [OUTW-1:0] pixel_v,
  output logic                   saturated
);

  localparam int unsigned SW = 44;

  logic                   mul_valid_r;
  logic signed [PRW-1:0]  prod_u_r, prod_v_r;
  logic signed [PRW-1:0]  prod_u_nxt, prod_v_nxt;
  logic signed [PW-1:0]   pu, pv;
  logic                   valid_r;
  logic signed [OUTW-1:0] pixel_u_r, pixel_v_r, pixel_u_nxt, pixel_v_nxt;
  logic                   sat_r, sat_nxt;
  logic signed [SW-1:0]   su, sv;

  always_comb begin
    pu = in_data.use_dist ? in_data.px : PW'(in_data.x);
    pv = in_data.use_dist ? in_data.py : PW'(in_data.y);
    prod_u_nxt = PRW'(signed'({1'b0, cfg.fu})) * PRW'(pu);
    prod_v_nxt = PRW'(signed'({1'b0, cfg.fv})) * PRW'(pv);
  end

  always_comb begin
    su = SW'(rnd(prod_u_r, 28)) + SW'(signed'({1'b0, cfg.cu}));
    sv = SW'(rnd(prod_v_r, 28)) + SW'(signed'({1'b0, cfg.cv}));
    sat_nxt = 1'b0;
    if (su > SW'(PIX_MAX)) begin
      pixel_u_nxt = PIX_MAX;
      sat_nxt = 1'b1;
    end else if (su < SW'(PIX_MIN)) begin
      pixel_u_nxt = PIX_MIN;
      sat_nxt = 1'b1;
    end else begin
      pixel_u_nxt = OUTW'(su);
    end
    if (sv > SW'(PIX_MAX)) begin
      pixel_v_nxt = PIX_MAX;
      sat_nxt = 1'b1;
    end else if (sv < SW'(PIX_MIN)) begin
      pixel_v_nxt = PIX_MIN;
      sat_nxt = 1'b1;
    end else begin
      pixel_v_nxt = OUTW'(sv);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
      valid_r <= 1'b0;
    end else if (en) begin
      mul_valid_r <= in_valid;
      valid_r <= mul_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_u_r  <= prod_u_nxt;
      prod_v_r  <= prod_v_nxt;
      pixel_u_r <= pixel_u_nxt;
      pixel_v_r <= pixel_v_nxt;
      sat_r     <= sat_nxt;
    end
  end

  assign out_valid = valid_r;
  assign pixel_u   = pixel_u_r;
  assign pixel_v   = pixel_v_r;
  assign saturated = sat_r;

endmodule

@@ rtl/fisheye_point_projection.sv @@
// Top level of the fixed-point equidistant fisheye point projection pipeline.
`timescale 1ns / 1ps
// Maps one normalized point per clock, unless the output stalls, to a pixel
// position with the equidistant fisheye model. The pipeline takes a new request
// in every cycle that in_ready is high and holds up to 2*CORDIC_STEPS + 16
// requests in flight, one per register stage: the two unrolled CORDIC chains
// (one step per stage, at most 32 steps), the rounding stage for the radius,
// the thirteen polynomial stages and the two stages of focal scaling. All
// stages advance together; when the result is not taken, the whole pipeline
// holds and in_ready drops, so a stall costs nothing but time. Distortion
// coefficients, focal lengths and the principal point are written through the
// cfg port; the user must write them only while no request is in flight, as
// the block itself does not enforce this.
module fisheye_point_projection
  import fpp_pkg::*;
#(
  parameter int unsigned COORD_WIDTH  = 24,
  parameter int unsigned CORDIC_STEPS = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_norm_x,
  input  logic signed [COORD_WIDTH-1:0] in_norm_y,
  input  logic                          in_apply_distortion,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [OUTW-1:0]        out_pixel_u,
  output logic signed [OUTW-1:0]        out_pixel_v,
  output logic                          out_saturated,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [KW-1:0]                 cfg_data
);

  localparam int unsigned NS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

  // Configuration registers.
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.k2 <= '0;
      cfg_r.k3 <= '0;
      cfg_r.k4 <= '0;
      cfg_r.k5 <= '0;
      cfg_r.fu <= KW'(4096);
      cfg_r.fv <= KW'(4096);
      cfg_r.cu <= '0;
      cfg_r.cv <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_K2: cfg_r.k2 <= cfg_data;
        REG_K3: cfg_r.k3 <= cfg_data;
        REG_K4: cfg_r.k4 <= cfg_data;
        REG_K5: cfg_r.k5 <= cfg_data;
        REG_FU: cfg_r.fu <= cfg_data;
        REG_FV: cfg_r.fv <= cfg_data;
        REG_CU: cfg_r.cu <= cfg_data;
        REG_CV: cfg_r.cv <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // The whole pipeline moves unless a finished result is waiting.
  logic en;
  assign en = ~(out_valid & ~out_ready);
  assign in_ready = en;

  // Entry: widen to Q.28 and fold the point into the right half plane.
  logic signed [XW-1:0] x_w, y_w;
  vec_t vec_in;

  always_comb begin
    x_w = XW'(in_norm_x) <<< (XW - COORD_WIDTH);
    y_w = XW'(in_norm_y) <<< (XW - COORD_WIDTH);
    vec_in.use_dist = in_apply_distortion & ((x_w != '0) | (y_w != '0));
    vec_in.fold = x_w[XW-1];
    vec_in.x    = x_w;
    vec_in.y    = y_w;
    vec_in.vx   = x_w[XW-1] ? -VW'(x_w) : VW'(x_w);
    vec_in.vy   = x_w[XW-1] ? -VW'(y_w) : VW'(y_w);
    vec_in.cx   = KINV;
    vec_in.cy   = '0;
  end

  // Vectoring on the point gives the radius and, through the same directions,
  // the unit vector (cos phi, sin phi).
  logic vec_valid [NS+1];
  vec_t vec_data  [NS+1];

  assign vec_valid[0] = in_valid;
  assign vec_data[0]  = vec_in;

  for (genvar i = 0; i < NS; i++) begin : g_vec
    fpp_vec_step #(.STEP(i)) u_step (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(vec_valid[i]), .in_data(vec_data[i]),
      .out_valid(vec_valid[i+1]), .out_data(vec_data[i+1])
    );
  end

  // Radius scaling by the inverse CORDIC gain and unfolding of the unit vector.
  logic   rad_valid_r;
  theta_t rad_r, rad_nxt;
  logic signed [PRW-1:0] rad_prod;

  always_comb begin
    rad_prod     = PRW'(vec_data[NS].vx) * PRW'(KINV);
    rad_nxt.use_dist = vec_data[NS].use_dist;
    rad_nxt.x    = vec_data[NS].x;
    rad_nxt.y    = vec_data[NS].y;
    rad_nxt.cx   = vec_data[NS].fold ? -vec_data[NS].cx : vec_data[NS].cx;
    rad_nxt.cy   = vec_data[NS].fold ? -vec_data[NS].cy : vec_data[NS].cy;
    rad_nxt.tx   = ONE_Q28;
    rad_nxt.ty   = TW'(rnd(rad_prod, 30));
    rad_nxt.z    = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rad_valid_r <= 1'b0;
    end else if (en) begin
      rad_valid_r <= vec_valid[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r <= rad_nxt;
    end
  end

  // theta = atan(r) by vectoring on (1, r).
  logic   th_valid [NS+1];
  theta_t th_data  [NS+1];

  assign th_valid[0] = rad_valid_r;
  assign th_data[0]  = rad_r;

  for (genvar i = 0; i < NS; i++) begin : g_theta
    fpp_theta_step #(.STEP(i)) u_step (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(th_valid[i]), .in_data(th_data[i]),
      .out_valid(th_valid[i+1]), .out_data(th_data[i+1])
    );
  end

  // Distortion polynomial by Horner's rule, then the distorted point.
  logic  pl_valid [POLY_STAGES+1];
  poly_t pl_data  [POLY_STAGES+1];
  poly_t pl_in;

  always_comb begin
    pl_in          = '0;
    pl_in.use_dist = th_data[NS].use_dist;
    pl_in.x        = th_data[NS].x;
    pl_in.y        = th_data[NS].y;
    pl_in.cx       = th_data[NS].cx;
    pl_in.cy       = th_data[NS].cy;
    pl_in.z        = th_data[NS].z;
  end

  assign pl_data[0]  = pl_in;
  assign pl_valid[0] = th_valid[NS];

  for (genvar j = 0; j < POLY_STAGES; j++) begin : g_poly
    fpp_poly_stage #(.OP(j)) u_stage (
      .clk(clk), .rst_n(rst_n), .en(en), .cfg(cfg_r),
      .in_valid(pl_valid[j]), .in_data(pl_data[j]),
      .out_valid(pl_valid[j+1]), .out_data(pl_data[j+1])
    );
  end

  // Focal scaling, offset and saturation; its last register is the output.
  fpp_pixel u_pixel (
    .clk(clk), .rst_n(rst_n), .en(en), .cfg(cfg_r),
    .in_valid(pl_valid[POLY_STAGES]), .in_data(pl_data[POLY_STAGES]),
    .out_valid(out_valid),
    .pixel_u(out_pixel_u), .pixel_v(out_pixel_v), .saturated(out_saturated)
  );

endmodule
